@@ design/fcc_pkg.sv @@
// Types and constants shared by the FAT cluster chain follower.
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

  localparam int unsigned CLUSTER_W   = 28;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned ENTRY_W     = 32;
  localparam int unsigned SECTOR_W    = 32;
  localparam int unsigned ADDR_W      = 41;
  localparam int unsigned LEFT_W      = 24;
  localparam int unsigned SHIFT_W     = 4;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 2;

  // log2 of the sector size in bytes
  localparam int unsigned SECTOR_BYTES_LOG2 = 9;
  localparam int unsigned BYTE_SHIFT_W      = 5;

  localparam logic [ENTRY_W-1:0] LAST_POINTER      = 32'hffff_ffef;
  localparam logic [ENTRY_W-1:0] ENTRY_MASK_WIDE   = 32'h0fff_ffff;
  localparam logic [ENTRY_W-1:0] ENTRY_MASK_NARROW = 32'h0000_ffff;
  localparam logic [ENTRY_W-1:0] FIRST_DATA_CLUSTER = 32'd2;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_ENTRY = 1'b1
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLUSTER_SHIFT = 2'd0,
    CFG_WIDE_ENTRIES  = 2'd1,
    CFG_FAT_START     = 2'd2,
    CFG_ROOT_START    = 2'd3
  } cfg_index_t;

endpackage

`default_nettype wire

@@ design/fcc_if.sv @@
// Valid/ready channels for chain follower items and results.
`timescale 1ns / 1ps
`default_nettype none

interface fcc_item_if
  import fcc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               func;
  logic [CLUSTER_W-1:0] start_cluster;
  logic [SIZE_W-1:0]  file_size;
  logic [ENTRY_W-1:0] fat_entry_bytes;

  modport source (
    output valid, func, start_cluster, file_size, fat_entry_bytes,
    input  ready
  );
  modport sink (
    input  valid, func, start_cluster, file_size, fat_entry_bytes,
    output ready
  );
endinterface

interface fcc_result_if
  import fcc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SECTOR_W-1:0] sector;
  logic [ADDR_W-1:0]   fat_read_addr;
  logic                sector_valid;
  logic                chain_end;
  logic                short_chain;

  modport source (
    output valid, sector, fat_read_addr, sector_valid, chain_end, short_chain,
    input  ready
  );
  modport sink (
    input  valid, sector, fat_read_addr, sector_valid, chain_end, short_chain,
    output ready
  );
endinterface

`default_nettype wire

@@ design/fat_cluster_chain_follower.sv @@
// FAT cluster chain follower: decodes table entries into sector and entry addresses.
//
// One transaction in, one transaction out. A start transaction loads the cluster
// count from the file size and returns the first sector and table entry address
// of the start cluster; each entry transaction byte-swaps and masks the raw table
// entry and either returns the next cluster's sector and entry address or flags
// the end of the chain (with short_chain set when the file size still asked for
// more clusters). The decode is a few shifts, masks and adds between the input
// handshake and a single result register, so a transaction is taken every cycle
// unless the sink stalls, and its result is valid in the next cycle; in a stall
// the result register holds and a new one is taken as soon as it drains or is taken.
// Configuration writes are applied at once and must only be issued while idle.
`timescale 1ns / 1ps
`default_nettype none

module fat_cluster_chain_follower
  import fcc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  fcc_item_if.sink                    item,
  fcc_result_if.source                res
);

  logic [SHIFT_W-1:0]  cluster_shift;
  logic                wide_entries;
  logic [SECTOR_W-1:0] fat_start_sector;
  logic [SECTOR_W-1:0] root_start_sector;

  logic [LEFT_W-1:0]   clusters_left;
  logic [LEFT_W-1:0]   clusters_left_next;

  logic                res_valid;
  logic [SECTOR_W-1:0] sector;
  logic [ADDR_W-1:0]   fat_read_addr;
  logic                sector_valid;
  logic                chain_end;
  logic                short_chain;

  logic [SECTOR_W-1:0] sector_next;
  logic [ADDR_W-1:0]   fat_read_addr_next;
  logic                sector_valid_next;
  logic                chain_end_next;
  logic                short_chain_next;

  logic                accept;
  logic [CLUSTER_W-1:0] cluster;
  logic [ENTRY_W-1:0]  entry_next;
  logic [ENTRY_W-1:0]  entry_last;
  logic                entry_stop;
  logic [LEFT_W-1:0]   left_dec;
  logic [BYTE_SHIFT_W-1:0] byte_shift;
  logic [SIZE_W-1:0]   size_quot;
  logic [SIZE_W-1:0]   size_rem_mask;
  logic [SIZE_W-1:0]   count;
  logic [SECTOR_W-1:0] cluster_minus_one;
  logic [ADDR_W-1:0]   fat_base;
  logic [ADDR_W-1:0]   entry_offset;

  assign accept     = item.valid && item.ready;
  assign item.ready = !res_valid || res.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_shift     <= SHIFT_W'(5);
      wide_entries      <= 1'b1;
      fat_start_sector  <= SECTOR_W'(8);
      root_start_sector <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_CLUSTER_SHIFT: cluster_shift     <= cfg_data[SHIFT_W-1:0];
        CFG_WIDE_ENTRIES:  wide_entries      <= cfg_data[0];
        CFG_FAT_START:     fat_start_sector  <= cfg_data[SECTOR_W-1:0];
        CFG_ROOT_START:    root_start_sector <= cfg_data[SECTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // cluster count, rounded up, from the file size
    byte_shift    = BYTE_SHIFT_W'(SECTOR_BYTES_LOG2) + BYTE_SHIFT_W'(cluster_shift);
    size_quot     = item.file_size >> byte_shift;
    size_rem_mask = ~(SIZE_W'('1) << byte_shift);
    count         = size_quot + SIZE_W'((item.file_size & size_rem_mask) != '0);

    // byte-swap and mask the table entry
    if (wide_entries) begin
      entry_next = {4'h0, item.fat_entry_bytes[3:0], item.fat_entry_bytes[15:8],
                    item.fat_entry_bytes[23:16], item.fat_entry_bytes[31:24]};
      entry_last = LAST_POINTER & ENTRY_MASK_WIDE;
    end else begin
      entry_next = {16'h0000, item.fat_entry_bytes[7:0], item.fat_entry_bytes[15:8]};
      entry_last = LAST_POINTER & ENTRY_MASK_NARROW;
    end
    entry_stop = (entry_next < FIRST_DATA_CLUSTER) || (entry_next > entry_last);
    left_dec   = (clusters_left != '0) ? clusters_left - LEFT_W'(1) : '0;

    if (func_t'(item.func) == FUNC_START) begin
      cluster = item.start_cluster;
    end else begin
      cluster = entry_next[CLUSTER_W-1:0];
    end

    cluster_minus_one = SECTOR_W'(cluster) - SECTOR_W'(1);
    fat_base          = ADDR_W'(fat_start_sector) << SECTOR_BYTES_LOG2;
    entry_offset      = wide_entries ? (ADDR_W'(cluster) << 2) : (ADDR_W'(cluster) << 1);

    sector_next        = (cluster_minus_one << cluster_shift) + root_start_sector;
    fat_read_addr_next = fat_base + entry_offset;
    sector_valid_next  = 1'b1;
    chain_end_next     = 1'b0;
    short_chain_next   = 1'b0;
    clusters_left_next = clusters_left;

    case (func_t'(item.func))
      FUNC_START: begin
        clusters_left_next = count[LEFT_W-1:0];
      end
      FUNC_ENTRY: begin
        clusters_left_next = left_dec;
        if (entry_stop) begin
          sector_next        = '0;
          fat_read_addr_next = '0;
          sector_valid_next  = 1'b0;
          chain_end_next     = 1'b1;
          short_chain_next   = (left_dec != '0);
        end
      end
      default: ;
    endcase
  end

  // Chain state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_left <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        clusters_left <= clusters_left_next;
        res_valid     <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      sector        <= sector_next;
      fat_read_addr <= fat_read_addr_next;
      sector_valid  <= sector_valid_next;
      chain_end     <= chain_end_next;
      short_chain   <= short_chain_next;
    end
  end

  assign res.valid         = res_valid;
  assign res.sector        = sector;
  assign res.fat_read_addr = fat_read_addr;
  assign res.sector_valid  = sector_valid;
  assign res.chain_end     = chain_end;
  assign res.short_chain   = short_chain;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the FAT cluster chain follower.
`timescale 1ns / 1ps

module testbench;
  import fcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct packed {
    func_t                func;
    logic [CLUSTER_W-1:0] start_cluster;
    logic [SIZE_W-1:0]    file_size;
    logic [ENTRY_W-1:0]   fat_entry_bytes;
  } chain_item_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [ADDR_W-1:0]   fat_read_addr;
    logic                sector_valid;
    logic                chain_end;
    logic                short_chain;
  } chain_result_t;

  bit clk;
  bit rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fcc_item_if   item_ch ();
  fcc_result_if res_ch ();

  fat_cluster_chain_follower u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .res       (res_ch)
  );

  logic [SHIFT_W-1:0]   cfg_shift = 4'd5;
  logic                 cfg_wide  = 1'b1;
  logic [31:0]          cfg_fat   = 32'd8;
  logic [31:0]          cfg_root  = 32'd0;
  logic [LEFT_W-1:0]    chain_left    = '0;

  chain_item_t   pending_items[$];
  chain_result_t results_due[$];

  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  logic        in_taken     = 1'b0;
  logic        calm         = 1'b0;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic chain_result_t cluster_place(input logic [CLUSTER_W-1:0] cl);
    chain_result_t r;
    logic [31:0]   base;
    logic [63:0]   addr;
    base = {4'b0, cl} - 32'd1;
    addr = ({32'b0, cfg_fat} << SECTOR_BYTES_LOG2) + ({36'b0, cl} << (cfg_wide ? 2 : 1));
    r.sector        = (base << cfg_shift) + cfg_root;
    r.fat_read_addr = addr[ADDR_W-1:0];
    r.sector_valid  = 1'b1;
    r.chain_end     = 1'b0;
    r.short_chain   = 1'b0;
    return r;
  endfunction

  function automatic chain_result_t follow_chain(input chain_item_t it);
    chain_result_t      r;
    logic [63:0]        per;
    logic [63:0]        cnt;
    logic [ENTRY_W-1:0] mask;
    logic [ENTRY_W-1:0] link;
    logic [ENTRY_W-1:0] e;
    e = it.fat_entry_bytes;
    if (it.func == FUNC_START) begin
      per = 64'd1 << (SECTOR_BYTES_LOG2 + cfg_shift);
      cnt = ({32'b0, it.file_size} + per - 64'd1) / per;
      chain_left    = cnt[LEFT_W-1:0];
      r = cluster_place(it.start_cluster);
    end else begin
      mask = cfg_wide ? ENTRY_MASK_WIDE : ENTRY_MASK_NARROW;
      link = cfg_wide ? {e[7:0], e[15:8], e[23:16], e[31:24]} : {16'b0, e[7:0], e[15:8]};
      link = link & mask;
      if (chain_left != 0) chain_left = chain_left - 1'b1;
      if (link < FIRST_DATA_CLUSTER || link > (LAST_POINTER & mask)) begin
        r = '0;
        r.chain_end   = 1'b1;
        r.short_chain = (chain_left != 0);
      end else begin
        r = cluster_place(link[CLUSTER_W-1:0]);
      end
    end
    return r;
  endfunction

  // encode a decoded table value as it lies on disk in the current entry width
  function automatic logic [ENTRY_W-1:0] on_disk(input logic [ENTRY_W-1:0] v);
    logic [31:0] w;
    logic [15:0] junk;
    junk = 16'($urandom);
    w    = {junk[3:0], v[27:0]};
    if (cfg_wide) return {w[7:0], w[15:8], w[23:16], w[31:24]};
    return {junk, v[7:0], v[15:8]};
  endfunction

  task automatic push_start(input logic [CLUSTER_W-1:0] cl, input logic [SIZE_W-1:0] sz);
    chain_item_t it;
    it.func            = FUNC_START;
    it.start_cluster   = cl;
    it.file_size       = sz;
    it.fat_entry_bytes = $urandom;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_entry(input logic [ENTRY_W-1:0] raw);
    chain_item_t it;
    it.func            = FUNC_ENTRY;
    it.start_cluster   = CLUSTER_W'($urandom);
    it.file_size       = $urandom;
    it.fat_entry_bytes = raw;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_CLUSTER_SHIFT: cfg_shift = val[SHIFT_W-1:0];
      CFG_WIDE_ENTRIES:  cfg_wide  = val[0];
      CFG_FAT_START:     cfg_fat   = val;
      CFG_ROOT_START:    cfg_root  = val;
      default: ;
    endcase
  endtask

  task automatic program_volume(input logic [SHIFT_W-1:0] shift, input logic wide,
                                input logic [31:0] fat, input logic [31:0] root);
    write_reg(CFG_CLUSTER_SHIFT, {28'b0, shift});
    write_reg(CFG_WIDE_ENTRIES, {31'b0, wide});
    write_reg(CFG_FAT_START, fat);
    write_reg(CFG_ROOT_START, root);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (items_taken != items_queued || results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic random_phase(input int target);
    int          made;
    int          len;
    int          c;
    logic [31:0] mask;
    logic [31:0] lim;
    logic [31:0] v;
    logic [63:0] per;
    logic [63:0] sz;
    made = 0;
    mask = cfg_wide ? ENTRY_MASK_WIDE : ENTRY_MASK_NARROW;
    lim  = LAST_POINTER & mask;
    per  = 64'd1 << (SECTOR_BYTES_LOG2 + cfg_shift);
    while (made < target) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1) == 0) push_start(CLUSTER_W'($urandom), $urandom);
        else push_entry($urandom);
        made++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 6);
        c   = $urandom_range(0, len + 2);
        sz  = c * per;
        if (c != 0) sz = sz - $urandom_range(0, 32'(per - 64'd1));
        if (sz > 64'hffff_ffff) sz = 64'hffff_ffff;
        if ($urandom_range(0, 7) == 0) sz = 64'($urandom);
        if ($urandom_range(0, 9) == 0) push_start(CLUSTER_W'($urandom), sz[31:0]);
        else push_start(CLUSTER_W'($urandom_range(2, lim)), sz[31:0]);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0:       v = FIRST_DATA_CLUSTER;
            1:       v = lim;
            default: v = $urandom_range(2, lim);
          endcase
          push_entry(on_disk(v));
        end
        // a chain left open is followed straight by the next start
        if ($urandom_range(0, 7) != 0) begin
          case ($urandom_range(0, 3))
            0:       v = 32'd0;
            1:       v = 32'd1;
            2:       v = $urandom_range(lim + 1, mask);
            default: v = mask;
          endcase
          push_entry(on_disk(v));
        end
        made += len + 2;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        item_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        chain_item_t nxt;
        nxt = pending_items.pop_front();
        item_ch.valid           <= 1'b1;
        item_ch.func            <= nxt.func;
        item_ch.start_cluster   <= nxt.start_cluster;
        item_ch.file_size       <= nxt.file_size;
        item_ch.fat_entry_bytes <= nxt.fat_entry_bytes;
        if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 3);
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 3);
    end
    res_ch.ready <= (hold_left == 0) && (stall_left == 0);
  end

  always @(posedge clk) begin
    chain_item_t   it;
    chain_result_t got;
    chain_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= item_ch.valid && item_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        got.sector        = res_ch.sector;
        got.fat_read_addr = res_ch.fat_read_addr;
        got.sector_valid  = res_ch.sector_valid;
        got.chain_end     = res_ch.chain_end;
        got.short_chain   = res_ch.short_chain;
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result transaction with nothing outstanding");
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: sector %h/%h addr %h/%h valid %b/%b end %b/%b short %b/%b",
                       want.sector, got.sector, want.fat_read_addr, got.fat_read_addr,
                       want.sector_valid, got.sector_valid, want.chain_end, got.chain_end,
                       want.short_chain, got.short_chain);
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        it.func            = func_t'(item_ch.func);
        it.start_cluster   = item_ch.start_cluster;
        it.file_size       = item_ch.file_size;
        it.fat_entry_bytes = item_ch.fat_entry_bytes;
        results_due.push_back(follow_chain(it));
        items_taken <= items_taken + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    item_ch.valid           = 1'b0;
    item_ch.func            = FUNC_START;
    item_ch.start_cluster   = '0;
    item_ch.file_size       = '0;
    item_ch.fat_entry_bytes = '0;
    res_ch.ready            = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_CLUSTER_SHIFT;
    cfg_data                = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    program_volume(4'd0, 1'b0, 32'd0, 32'd0);
    push_start(28'd0, 32'd0);
    push_entry(on_disk(32'd0));
    push_start(28'd1, 32'd1);
    push_entry(on_disk(32'd2));
    push_entry(on_disk(32'h0000_ffef));
    push_entry(on_disk(32'h0000_fff7));
    push_start(28'hfff_ffff, 32'hffff_ffff);
    push_entry(on_disk(32'd0));
    push_entry(on_disk(32'd1));
    push_entry(32'hffff_ffff);
    push_entry(on_disk(32'h0000_fff0));
    push_entry(32'h0000_0300);
    drain();

    program_volume(4'd15, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
    push_start(28'hfff_ffff, 32'hffff_ffff);
    push_entry(32'hefff_ffff);
    push_entry(on_disk(32'h0fff_fff0));
    push_entry(on_disk(32'd2));
    push_entry(on_disk(32'h0fff_fff7));
    push_entry(32'hffff_ffff);
    push_start(28'd2, 32'd1);
    push_entry(on_disk(32'd0));
    push_start(28'd1, 32'h0100_0001);
    drain();

    program_volume(4'd8, 1'b0, $urandom, $urandom);
    random_phase(130);
    drain();

    program_volume(SHIFT_W'($urandom_range(0, 8)), 1'b1, $urandom, $urandom);
    random_phase(130);
    hold_req = 1'b1;
    drain();

    program_volume(SHIFT_W'($urandom_range(0, 8)), 1'($urandom_range(0, 1)),
                   $urandom, $urandom);
    random_phase(130);
    drain();

    program_volume(4'd5, 1'b1, 32'd8, 32'd0);
    random_phase(130);
    drain();

    calm = 1'b1;
    program_volume(SHIFT_W'($urandom_range(0, 8)), 1'($urandom_range(0, 1)),
                   $urandom, $urandom);
    random_phase(130);
    drain();

    if (results_due.size() != 0) fail_count += results_due.size();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
